/* hw/rtl/pcx_rle_decoder_unit_macros.svh */
// Assertion macros used by the PCX run-length decoder RTL
`ifndef PCX_RLE_DECODER_UNIT_MACROS_SVH
`define PCX_RLE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, masked while in reset
`define PCX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, masked while in reset
`define PCX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pcx_pkg.sv */
// Shared types and constants for the PCX run-length decoder
package pcx_pkg;

    localparam int COL_W      = 13;
    localparam int CNT_W      = 6;
    localparam int PLANE_W    = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam int DEF_MAX_LINE_BYTES = 4096;
    localparam int DEF_MAX_PLANES     = 4;

    localparam logic [COL_W-1:0] RESET_BYTES  = 13'd80;
    localparam logic [2:0]       RESET_PLANES = 3'd1;

    // register index codes (paddr[2])
    localparam logic REG_BYTES  = 1'b0;
    localparam logic REG_PLANES = 1'b1;

    // top two bits set marks a count byte
    localparam logic [1:0] COUNT_MARK = 2'b11;

    typedef struct packed {
        logic             is_eos;
        logic             trunc;
        logic [7:0]       value;
        logic [CNT_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

endpackage

/* hw/rtl/pcx_front.sv */
// Front end: takes input words, tracks count bytes, queues run commands
module pcx_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_code_byte,
    input  logic           i_end_of_stream,
    input  logic           i_full,
    output pcx_pkg::t_push o_push
);
    import pcx_pkg::*;

    logic             r_awaiting;
    logic [CNT_W-1:0] r_count;
    logic             n_awaiting;
    logic [CNT_W-1:0] n_count;
    logic             w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;

    always_comb begin
        n_awaiting         = r_awaiting;
        n_count            = r_count;
        o_push.valid       = 1'b0;
        o_push.cmd.is_eos  = 1'b0;
        o_push.cmd.trunc   = 1'b0;
        o_push.cmd.value   = i_code_byte;
        o_push.cmd.count   = CNT_W'(1);
        if (w_accept) begin
            priority if (i_end_of_stream) begin
                o_push.valid      = 1'b1;
                o_push.cmd.is_eos = 1'b1;
                o_push.cmd.trunc  = r_awaiting;
                o_push.cmd.value  = '0;
                n_awaiting        = 1'b0;
                n_count           = '0;
            end else if (r_awaiting) begin
                // zero count swallows the value byte
                o_push.valid     = (r_count != '0);
                o_push.cmd.count = r_count;
                n_awaiting       = 1'b0;
            end else if (i_code_byte[7:6] == COUNT_MARK) begin
                n_awaiting = 1'b1;
                n_count    = i_code_byte[CNT_W-1:0];
            end else begin
                o_push.valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_count    <= '0;
        end else begin
            r_awaiting <= n_awaiting;
            r_count    <= n_count;
        end
    end

endmodule

/* hw/rtl/pcx_queue.sv */
// Short command queue between front and back
module pcx_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pcx_pkg::t_push i_push,
    output logic           o_full,
    output logic           o_valid,
    output pcx_pkg::t_cmd  o_cmd,
    input  logic           i_pop
);
    import pcx_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_fill;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_fill == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_wr    = i_push.valid && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_fill <= r_fill + (PTR_W+1)'(1);
                2'b01:   r_fill <= r_fill - (PTR_W+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

/* hw/rtl/pcx_back.sv */
// Back end: expands queued runs into output words with plane and column
`include "pcx_rle_decoder_unit_macros.svh"

module pcx_back #(
    parameter int MAX_LINE_BYTES = pcx_pkg::DEF_MAX_LINE_BYTES,
    parameter int MAX_PLANES     = pcx_pkg::DEF_MAX_PLANES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pcx_pkg::COL_W-1:0]  i_bytes_per_line,
    input  logic [2:0]                 i_planes_per_line,
    input  logic                       i_q_valid,
    input  pcx_pkg::t_cmd              i_q_cmd,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_pixel_byte,
    output logic                       o_data_valid,
    output logic [1:0]                 o_plane_index,
    output logic [11:0]                o_column,
    output logic                       o_line_done,
    output logic                       o_run_last,
    output logic                       o_truncated
);
    import pcx_pkg::*;

    localparam int CapBytesI = (MAX_LINE_BYTES > 8191) ? 8191 : MAX_LINE_BYTES;
    localparam logic [COL_W-1:0] CapBytes  = COL_W'(CapBytesI);
    localparam logic [2:0]       CapPlanes = 3'(MAX_PLANES);

    // current command
    logic               r_busy;
    logic               r_eos;
    logic               r_trunc;
    logic [7:0]         r_value;
    logic [CNT_W-1:0]   r_left;
    // position
    logic [COL_W-1:0]   r_col;
    logic [PLANE_W-1:0] r_plane;
    // output register
    logic               r_out_valid;
    logic [7:0]         r_out_pixel;
    logic               r_out_data;
    logic [PLANE_W-1:0] r_out_plane;
    logic [11:0]        r_out_col;
    logic               r_out_done;
    logic               r_out_last;
    logic               r_out_trunc;

    logic [COL_W-1:0]   w_bpl;
    logic [2:0]         w_ppl;
    logic               w_load;
    logic               w_plane_end;
    logic               w_line_end;
    logic               w_last;

    always_comb begin
        if (i_bytes_per_line == '0) begin
            w_bpl = COL_W'(1);
        end else if (i_bytes_per_line > CapBytes) begin
            w_bpl = CapBytes;
        end else begin
            w_bpl = i_bytes_per_line;
        end
        if (i_planes_per_line == '0) begin
            w_ppl = 3'd1;
        end else if (i_planes_per_line > CapPlanes) begin
            w_ppl = CapPlanes;
        end else begin
            w_ppl = i_planes_per_line;
        end
    end

    assign w_load      = r_busy && (!r_out_valid || i_ready);
    assign w_plane_end = ({1'b0, r_col} + (COL_W+1)'(1)) >= {1'b0, w_bpl};
    assign w_line_end  = ({1'b0, r_plane} + 3'd1) >= w_ppl;
    assign w_last      = r_eos || w_plane_end || (r_left == CNT_W'(1));
    assign o_pop       = i_q_valid && (!r_busy || (w_load && w_last));

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_eos) begin
                r_out_pixel <= '0;
                r_out_data  <= 1'b0;
                r_out_plane <= '0;
                r_out_col   <= '0;
                r_out_done  <= 1'b0;
                r_out_last  <= 1'b1;
                r_out_trunc <= r_trunc;
            end else begin
                r_out_pixel <= r_value;
                r_out_data  <= 1'b1;
                r_out_plane <= r_plane;
                r_out_col   <= r_col[11:0];
                r_out_done  <= w_plane_end && w_line_end;
                r_out_last  <= w_last;
                r_out_trunc <= 1'b0;
            end
        end
        if (o_pop) begin
            r_eos   <= i_q_cmd.is_eos;
            r_trunc <= i_q_cmd.trunc;
            r_value <= i_q_cmd.value;
            r_left  <= i_q_cmd.count;
        end else if (w_load) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_col       <= '0;
            r_plane     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (w_load && w_last) begin
                r_busy <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load) begin
                if (r_eos) begin
                    r_col   <= '0;
                    r_plane <= '0;
                end else if (w_plane_end) begin
                    r_col   <= '0;
                    r_plane <= w_line_end ? '0 : r_plane + PLANE_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_byte  = r_out_pixel;
    assign o_data_valid  = r_out_data;
    assign o_plane_index = r_out_plane;
    assign o_column      = r_out_col;
    assign o_line_done   = r_out_done;
    assign o_run_last    = r_out_last;
    assign o_truncated   = r_out_trunc;

    `PCX_ASSERT_NOW(a_pop_needs_cmd, o_pop, i_q_valid, "pop from empty queue")
    `PCX_ASSERT_NOW(a_run_has_bytes, r_busy && !r_eos, r_left != '0, "run active with no bytes")
    `PCX_ASSERT_NEXT(a_eos_clears_pos, w_load && r_eos, r_col == '0 && r_plane == '0, "end word left position")
    `PCX_ASSERT_NOW(a_done_is_last, r_out_valid && r_out_done, r_out_last && r_out_data, "line end not last")

endmodule

/* hw/rtl/pcx_rle_decoder_unit.sv */
// PCX run-length decoder top level: config registers, front, queue, back
//
//  channel   dir  handshake                 payload
//  s_axis    in   i_s_axis_tvalid/tready    tdata code_byte, tuser end_of_stream
//  m_axis    out  o_m_axis_tvalid/tready    tdata pixel/plane/column, tuser flags, tlast
//  apb       in   psel/penable/pwrite       bytes_per_line @0x0, planes_per_line @0x4
//
// One input word per cycle into a 4-deep command queue; count bytes make no output.
// The back end emits one decoded word per cycle while the output is ready and takes
// the next command with a run's last byte; input stalls only once the queue fills.
// An input word reaches the output via the queue entry, command and output registers.
// Synchronous active-low reset clears decode state; registers return to 80 and 1.
module pcx_rle_decoder_unit #(
    parameter int MAX_LINE_BYTES = pcx_pkg::DEF_MAX_LINE_BYTES,
    parameter int MAX_PLANES     = pcx_pkg::DEF_MAX_PLANES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] code_byte
    input  logic        i_s_axis_tuser,   // [0] end_of_stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] pixel_byte, [9:8] plane_index,
                                          // [21:10] column, [23:22] zero
    output logic [2:0]  o_m_axis_tuser,   // [0] data_valid, [1] line_done, [2] truncated
    output logic        o_m_axis_tlast,   // run_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pcx_pkg::*;

    logic [COL_W-1:0] r_bytes_per_line;
    logic [2:0]       r_planes_per_line;
    t_push            w_push;
    logic             w_full;
    logic             w_q_valid;
    t_cmd             w_q_cmd;
    logic             w_pop;
    logic [7:0]       w_pixel;
    logic             w_data_valid;
    logic [1:0]       w_plane;
    logic [11:0]      w_column;
    logic             w_line_done;
    logic             w_truncated;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_per_line  <= RESET_BYTES;
            r_planes_per_line <= RESET_PLANES;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_BYTES:  r_bytes_per_line  <= pwdata[COL_W-1:0];
                REG_PLANES: r_planes_per_line <= pwdata[2:0];
                default:    r_bytes_per_line  <= r_bytes_per_line;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BYTES:  prdata = {{(32-COL_W){1'b0}}, r_bytes_per_line};
            REG_PLANES: prdata = {29'b0, r_planes_per_line};
            default:    prdata = '0;
        endcase
    end

    pcx_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_code_byte     (i_s_axis_tdata),
        .i_end_of_stream (i_s_axis_tuser),
        .i_full          (w_full),
        .o_push          (w_push)
    );

    pcx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    pcx_back #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .MAX_PLANES     (MAX_PLANES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_bytes_per_line  (r_bytes_per_line),
        .i_planes_per_line (r_planes_per_line),
        .i_q_valid         (w_q_valid),
        .i_q_cmd           (w_q_cmd),
        .o_pop             (w_pop),
        .o_valid           (o_m_axis_tvalid),
        .i_ready           (i_m_axis_tready),
        .o_pixel_byte      (w_pixel),
        .o_data_valid      (w_data_valid),
        .o_plane_index     (w_plane),
        .o_column          (w_column),
        .o_line_done       (w_line_done),
        .o_run_last        (o_m_axis_tlast),
        .o_truncated       (w_truncated)
    );

    assign o_m_axis_tdata = {2'b00, w_column, w_plane, w_pixel};
    assign o_m_axis_tuser = {w_truncated, w_line_done, w_data_valid};

endmodule
